// ===== rtl/core/pts_pkg.sv =====
// Package for the priority tick task scheduler.
// Holds operation and status codes, the item structs and table constants.
// No dependencies.
package pts_pkg;

  localparam int unsigned MaxTasksDefault = 16;
  localparam int unsigned DueW = 17;
  localparam int unsigned WordW = 16;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_DORMANT = 3'd2,
    OP_ACTIVE  = 3'd3,
    OP_TICK    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Active mark values.
  localparam logic StateDormant    = 1'b0;
  localparam logic StateNotDormant = 1'b1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  slot;
    logic [15:0] task_handle;
    logic [15:0] task_priority;
    logic [15:0] task_period;
    logic        run_once;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  assigned_slot;
    logic        dispatched;
    logic [15:0] dispatched_handle;
    logic [3:0]  dispatched_slot;
    logic        moved;
    logic [3:0]  moved_to_slot;
    logic [15:0] moved_handle;
  } out_item_t;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [DueW-1:0]  due;
    logic [WordW-1:0] period;
    logic [WordW-1:0] prio;
    logic [WordW-1:0] handle;
    logic             run_once;
    logic             active;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

// ===== rtl/core/priority_tick_task_scheduler_core.sv =====
// Priority tick task scheduler: a packed task table in one RAM and the
// sequencer that serves create, delete, dormant, active and tick items.
// Depends on pts_pkg and pts_ram.

// One item is served at a time, and a new item is taken only once the last
// result has left the output register. Create, dormant, active and unknown
// codes pass through the read, wait, execute and done states; delete also
// reads the last entry and copies it over the freed slot. A tick reads every
// live entry through the RAM read port, one per cycle; a dispatch then reads
// the best entry back and moves its due time on, or removes a one-shot task
// the way a delete does. While a counter wrap is pending, the scan writes each
// cut due time back. The table RAM needs no clearing after reset: only entries
// below the task count are ever read.
module priority_tick_task_scheduler_core
  import pts_pkg::*;
#(
  parameter int unsigned MaxTasks = MaxTasksDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned CntW = $clog2(MaxTasks + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_EXEC, S_SCAN, S_BEST_RD, S_BEST_WAIT,
    S_LAST_RD, S_LAST_WAIT, S_COPY, S_DONE
  } state_e;

  state_e            state_q;
  in_item_t          req_q;
  logic [CntW-1:0]   count_q;
  logic [15:0]       tick_q;
  logic              wrap_q;
  logic [CntW-1:0]   scan_q;
  logic [CntW-1:0]   scan_rd_q;
  logic              scan_vld_q;
  logic              found_q;
  logic [IdxW-1:0]   best_q;
  logic [15:0]       best_prio_q;
  logic [IdxW-1:0]   target_q;
  out_item_t         res_q;
  logic              out_valid_q;

  logic              we;
  logic [IdxW-1:0]   waddr;
  logic [IdxW-1:0]   raddr;
  entry_t            wdata;
  entry_t            rdata;
  logic [EntryW-1:0] rdata_raw;

  pts_ram #(.Width(EntryW), .Depth(MaxTasks)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  // Scan view of the entry being read: due time cut while wrap is pending.
  logic [DueW-1:0] scan_due;
  logic            scan_ready;
  logic [IdxW-1:0] last_idx;
  logic            slot_ok;
  assign scan_due   = wrap_q ? {1'b0, rdata.due[15:0]} : rdata.due;
  assign scan_ready = rdata.active && (scan_due <= {1'b0, tick_q});
  assign last_idx   = IdxW'(count_q - CntW'(1));
  assign slot_ok    = (CntW'(req_q.slot) < count_q) && (32'(req_q.slot) < MaxTasks);

  // RAM port control.
  always_comb begin
    we    = 1'b0;
    waddr = IdxW'(req_q.slot);
    wdata = rdata;
    raddr = IdxW'(req_q.slot);
    case (state_q)
      S_SCAN: begin
        raddr = IdxW'(scan_q);
        // While a wrap is pending, the cut due time is stored back.
        if (scan_vld_q && wrap_q) begin
          we        = 1'b1;
          waddr     = IdxW'(scan_rd_q);
          wdata.due = scan_due;
        end
      end
      S_BEST_RD: raddr = best_q;
      S_LAST_RD, S_LAST_WAIT: raddr = last_idx;
      S_EXEC: begin
        case (op_e'(req_q.operation))
          OP_CREATE: begin
            if (count_q < CntW'(MaxTasks) && req_q.task_handle != '0) begin
              we             = 1'b1;
              waddr          = IdxW'(count_q);
              wdata.due      = DueW'({1'b0, tick_q} + {1'b0, req_q.task_period});
              wdata.period   = req_q.task_period;
              wdata.prio     = req_q.task_priority;
              wdata.handle   = req_q.task_handle;
              wdata.run_once = req_q.run_once;
              wdata.active   = StateNotDormant;
            end
          end
          OP_DORMANT: begin
            we = slot_ok;
            wdata.active = StateDormant;
          end
          OP_ACTIVE: begin
            we = slot_ok;
            wdata.active = StateNotDormant;
            wdata.due = DueW'({1'b0, tick_q} + {1'b0, rdata.period});
          end
          default: ;
        endcase
      end
      S_BEST_WAIT: begin
        // Periodic dispatch: due time (as seen by the scan) moves on.
        we    = !rdata.run_once;
        waddr = best_q;
        wdata.due = DueW'({1'b0, scan_due} + {1'b0, rdata.period});
      end
      S_COPY: begin
        we    = (target_q != last_idx);
        waddr = target_q;
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

  // Sequencer, counters and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      tick_q      <= '0;
      wrap_q      <= 1'b0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      scan_rd_q   <= '0;
      scan_vld_q  <= 1'b0;
      found_q     <= 1'b0;
      best_q      <= '0;
      best_prio_q <= '0;
      target_q    <= '0;
      req_q       <= '0;
      res_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            req_q   <= in_item_i;
            res_q   <= '0;
            state_q <= S_RD;
          end
        end
        S_RD: begin
          if (op_e'(req_q.operation) == OP_TICK) begin
            if (tick_q == 16'hFFFF) begin
              wrap_q <= 1'b1;
            end
            tick_q     <= tick_q + 16'd1;
            scan_q     <= '0;
            scan_vld_q <= 1'b0;
            found_q    <= 1'b0;
            state_q    <= S_SCAN;
          end else begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: state_q <= S_EXEC;
        S_EXEC: begin
          state_q <= S_DONE;
          case (op_e'(req_q.operation))
            OP_CREATE: begin
              if (count_q >= CntW'(MaxTasks)) begin
                res_q.status <= ST_FULL;
              end else if (req_q.task_handle == '0) begin
                res_q.status <= ST_NULL;
              end else begin
                res_q.assigned_slot <= 4'(count_q);
                count_q <= count_q + CntW'(1);
              end
            end
            OP_DELETE: begin
              if (!slot_ok) begin
                res_q.status <= ST_NOT_FOUND;
              end else begin
                target_q <= IdxW'(req_q.slot);
                state_q  <= S_LAST_RD;
              end
            end
            OP_DORMANT, OP_ACTIVE: begin
              if (!slot_ok) begin
                res_q.status <= ST_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          // One read issued per cycle; compare the entry read last cycle.
          scan_vld_q <= (scan_q < count_q);
          scan_rd_q  <= scan_q;
          if (scan_vld_q && scan_ready &&
              (!found_q || best_prio_q > rdata.prio)) begin
            found_q     <= 1'b1;
            best_q      <= IdxW'(scan_rd_q);
            best_prio_q <= rdata.prio;
          end
          if (scan_q >= count_q && !scan_vld_q) begin
            state_q <= found_q ? S_BEST_RD : S_DONE;
          end else if (scan_q < count_q) begin
            scan_q <= scan_q + CntW'(1);
          end
        end
        S_BEST_RD: state_q <= S_BEST_WAIT;
        S_BEST_WAIT: begin
          res_q.dispatched        <= 1'b1;
          res_q.dispatched_handle <= rdata.handle;
          res_q.dispatched_slot   <= 4'(best_q);
          wrap_q                  <= 1'b0;
          if (rdata.run_once) begin
            target_q <= best_q;
            state_q  <= S_LAST_RD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_LAST_RD: state_q <= S_LAST_WAIT;
        S_LAST_WAIT: state_q <= S_COPY;
        S_COPY: begin
          count_q <= count_q - CntW'(1);
          if (target_q != last_idx) begin
            res_q.moved         <= 1'b1;
            res_q.moved_to_slot <= 4'(target_q);
            res_q.moved_handle  <= rdata.handle;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The task count never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(MaxTasks))
    else $error("task count above table depth");

  // A new item is never taken while a result is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_q |-> state_q == S_IDLE)
    else $error("sequencer busy while result pending");

  // A dispatch clears the wrap flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BEST_WAIT |=> !wrap_q)
    else $error("wrap flag survived a dispatch");

  // A table write always lands inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> 32'(waddr) < MaxTasks)
    else $error("table write out of range");

endmodule

// ===== rtl/core/pts_ram.sv =====
// Generic simple dual-port synchronous RAM (one write, one read port) with registered read data.
// No dependencies.
module pts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== bench/testbench.sv =====
// Testbench for the priority tick task scheduler core.
// Drives create, delete, dormant, active and tick items and checks each result
// against a local scheduler predictor. Depends on pts_pkg and the core RTL.
module testbench
  import pts_pkg::*;
();

  localparam int Depth = 16;
  localparam int unsigned CycleLimit = 400000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  priority_tick_task_scheduler_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // Predicted task table.
  logic [16:0] tbl_due     [Depth];
  logic [15:0] tbl_period  [Depth];
  logic [15:0] tbl_prio    [Depth];
  logic [15:0] tbl_handle  [Depth];
  logic        tbl_shot    [Depth];
  logic        tbl_active  [Depth];
  int          live_tasks;
  logic [15:0] tick_now;
  logic        wrapped;

  out_item_t   expected_results[$];
  int          error_count;
  int unsigned cycle_count;
  logic        idle_off;
  logic        long_hold;

  // Directed rows; check_row marks rows whose result is typed in.
  typedef struct {
    in_item_t  item;
    logic      check_row;
    out_item_t result;
  } dir_row_t;
  dir_row_t dir_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Cycle counter and timeout.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  // Remove one entry by moving the last one into its slot.
  function automatic void drop_task(input int idx, inout out_item_t r);
    int last;
    last = live_tasks - 1;
    live_tasks = last;
    if (idx != last) begin
      tbl_due[idx]    = tbl_due[last];
      tbl_period[idx] = tbl_period[last];
      tbl_prio[idx]   = tbl_prio[last];
      tbl_handle[idx] = tbl_handle[last];
      tbl_shot[idx]   = tbl_shot[last];
      tbl_active[idx] = tbl_active[last];
      r.moved = 1'b1;
      r.moved_to_slot = idx[3:0];
      r.moved_handle = tbl_handle[idx];
    end
  endfunction

  // Scheduler predictor: updates the table and returns the expected result.
  function automatic out_item_t schedule_step(input in_item_t it);
    out_item_t r;
    logic      found;
    int        best;
    r = '0;
    found = 1'b0;
    best = 0;
    case (it.operation)
      OP_CREATE: begin
        if (live_tasks >= Depth) begin
          r.status = ST_FULL;
        end else if (it.task_handle == 16'd0) begin
          r.status = ST_NULL;
        end else begin
          tbl_handle[live_tasks] = it.task_handle;
          tbl_prio[live_tasks]   = it.task_priority;
          tbl_period[live_tasks] = it.task_period;
          tbl_shot[live_tasks]   = it.run_once;
          tbl_due[live_tasks]    = {1'b0, tick_now} + {1'b0, it.task_period};
          tbl_active[live_tasks] = StateNotDormant;
          r.assigned_slot = live_tasks[3:0];
          live_tasks++;
        end
      end
      OP_DELETE, OP_DORMANT, OP_ACTIVE: begin
        if (int'(it.slot) >= live_tasks) begin
          r.status = ST_NOT_FOUND;
        end else if (it.operation == OP_DELETE) begin
          drop_task(int'(it.slot), r);
        end else if (it.operation == OP_DORMANT) begin
          tbl_active[it.slot] = StateDormant;
        end else begin
          tbl_active[it.slot] = StateNotDormant;
          tbl_due[it.slot] = {1'b0, tick_now} + {1'b0, tbl_period[it.slot]};
        end
      end
      OP_TICK: begin
        if (tick_now == 16'hFFFF) wrapped = 1'b1;
        tick_now = tick_now + 16'd1;
        for (int i = 0; i < live_tasks; i++) begin
          if (wrapped) tbl_due[i][16] = 1'b0;
          if (tbl_active[i] && tbl_due[i] <= {1'b0, tick_now}) begin
            if (!found) begin
              best = i;
              found = 1'b1;
            end else if (tbl_prio[best] > tbl_prio[i]) begin
              best = i;
            end
          end
        end
        if (found) begin
          r.dispatched = 1'b1;
          r.dispatched_handle = tbl_handle[best];
          r.dispatched_slot = best[3:0];
          if (tbl_shot[best]) drop_task(best, r);
          else tbl_due[best] = tbl_due[best] + {1'b0, tbl_period[best]};
          wrapped = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Receiver: random stall bursts, one long hold-off, checks at rising edge.
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9);
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 16'(out_item_o.status), 16'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.status != want.status)
          report_mismatch("status", 16'(out_item_o.status), 16'(want.status));
        if (out_item_o.assigned_slot != want.assigned_slot)
          report_mismatch("assigned_slot", 16'(out_item_o.assigned_slot),
                          16'(want.assigned_slot));
        if (out_item_o.dispatched != want.dispatched)
          report_mismatch("dispatched", 16'(out_item_o.dispatched), 16'(want.dispatched));
        if (out_item_o.dispatched_handle != want.dispatched_handle)
          report_mismatch("dispatched_handle", out_item_o.dispatched_handle,
                          want.dispatched_handle);
        if (out_item_o.dispatched_slot != want.dispatched_slot)
          report_mismatch("dispatched_slot", 16'(out_item_o.dispatched_slot),
                          16'(want.dispatched_slot));
        if (out_item_o.moved != want.moved)
          report_mismatch("moved", 16'(out_item_o.moved), 16'(want.moved));
        if (out_item_o.moved_to_slot != want.moved_to_slot)
          report_mismatch("moved_to_slot", 16'(out_item_o.moved_to_slot),
                          16'(want.moved_to_slot));
        if (out_item_o.moved_handle != want.moved_handle)
          report_mismatch("moved_handle", out_item_o.moved_handle, want.moved_handle);
      end
    end
  end

  // Send one item, predicting at acceptance; a typed-in result is also checked.
  // Valid stays up after the accepting edge; the caller drops it before idling.
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t typed_res);
    out_item_t pred;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pred = schedule_step(it);
    if (typed && pred != typed_res)
      report_mismatch("table row", 16'(pred.status), 16'(typed_res.status));
    expected_results.push_back(pred);
    @(negedge clk_i);
  endtask

  function automatic in_item_t make_item(input op_e op, input logic [3:0] slot,
                                         input logic [15:0] h, input logic [15:0] p,
                                         input logic [15:0] per, input logic shot);
    in_item_t it;
    it.operation = op;
    it.slot = slot;
    it.task_handle = h;
    it.task_priority = p;
    it.task_period = per;
    it.run_once = shot;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it = '0;
    it.task_handle   = $urandom_range(0, 15) == 0 ? 16'd0 : 16'($urandom);
    it.task_priority = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 7));
    it.task_period   = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6));
    it.run_once      = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 25) it.operation = OP_CREATE;
    else if (pick < 35) it.operation = OP_DELETE;
    else if (pick < 42) it.operation = OP_DORMANT;
    else if (pick < 49) it.operation = OP_ACTIVE;
    else if (pick < 97) it.operation = OP_TICK;
    else it.operation = 3'($urandom_range(5, 7));
    it.slot = (live_tasks > 0 && $urandom_range(0, 7) != 0) ?
              4'($urandom_range(0, live_tasks - 1)) : 4'($urandom);
    return it;
  endfunction

  task automatic add_row(input in_item_t it, input logic typed, input out_item_t res);
    dir_row_t row;
    row.item = it;
    row.check_row = typed;
    row.result = res;
    dir_rows.push_back(row);
  endtask

  // Stimulus.
  initial begin
    out_item_t r;
    int        gap;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    error_count = 0;
    idle_off = 1'b0;
    long_hold = 1'b0;
    live_tasks = 0;
    tick_now = '0;
    wrapped = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: errors on empty table, extremes, ties, one-shot, dormant.
    r = '0; r.status = ST_NOT_FOUND;
    add_row(make_item(OP_DELETE, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0), 1'b1, r);
    add_row(make_item(OP_DORMANT, 4'hF, 16'h0, 16'h0, 16'h0, 1'b0), 1'b1, r);
    add_row(make_item(OP_ACTIVE, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0), 1'b1, r);
    r = '0; r.status = ST_NULL;
    add_row(make_item(OP_CREATE, 4'd0, 16'h0, 16'h5, 16'h1, 1'b0), 1'b1, r);
    r = '0;
    add_row(make_item(OP_TICK, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0), 1'b1, r);
    add_row(make_item(op_e'(3'd7), 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1), 1'b1, r);
    add_row(make_item(OP_CREATE, 4'd0, 16'hFFFF, 16'hFFFF, 16'h1, 1'b0), 1'b1, r);
    r.assigned_slot = 4'd1;
    add_row(make_item(OP_CREATE, 4'd0, 16'h0001, 16'h0000, 16'h1, 1'b1), 1'b1, r);
    add_row(make_item(OP_CREATE, 4'd0, 16'h1234, 16'h0000, 16'hFFFF, 1'b0), 1'b0, r);
    add_row(make_item(OP_CREATE, 4'd0, 16'h5555, 16'h0000, 16'h2, 1'b0), 1'b0, r);
    add_row(make_item(OP_TICK, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0), 1'b0, r);
    add_row(make_item(OP_TICK, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0), 1'b0, r);
    add_row(make_item(OP_DORMANT, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0), 1'b0, r);
    add_row(make_item(OP_TICK, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0), 1'b0, r);
    add_row(make_item(OP_ACTIVE, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0), 1'b0, r);
    add_row(make_item(OP_DELETE, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0), 1'b0, r);
    for (int i = 0; i < 14; i++)
      add_row(make_item(OP_CREATE, 4'd0, 16'(i + 100), 16'(i), 16'h8000, 1'b0), 1'b0, r);
    r = '0; r.status = ST_FULL;
    add_row(make_item(OP_CREATE, 4'd0, 16'h7777, 16'h0, 16'h1, 1'b1), 1'b1, r);
    add_row(make_item(OP_DELETE, 4'hF, 16'h0, 16'h0, 16'h0, 1'b0), 1'b0, r);

    foreach (dir_rows[k]) send_item(dir_rows[k].item, dir_rows[k].check_row,
                                    dir_rows[k].result);

    // Clear the table so random work starts small.
    while (live_tasks > 0)
      send_item(make_item(OP_DELETE, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, r);

    // Random part, with one long receiver hold-off and a gap-free tail.
    for (int n = 0; n < 420; n++) begin
      if (n == 130) fork
        begin
          long_hold = 1'b1;
          repeat (300) @(posedge clk_i);
          long_hold = 1'b0;
        end
      join_none
      if (n == 350) idle_off = 1'b1;
      if (!idle_off && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 9);
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      send_item(random_item(), 1'b0, r);
    end
    // A long-period task beside a one-shot task, then a run of ticks.
    while (live_tasks > 0)
      send_item(make_item(OP_DELETE, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, r);
    send_item(make_item(OP_CREATE, 4'd0, 16'hABCD, 16'd3, 16'hFFF8, 1'b0), 1'b0, r);
    send_item(make_item(OP_CREATE, 4'd0, 16'hBEEF, 16'd1, 16'd20, 1'b1), 1'b0, r);
    for (int n = 0; n < 30; n++)
      send_item(make_item(OP_TICK, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b0, r);
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
